[rtl/rri_pkg.sv]
// ----------------------------------------------------------------------------
// rri_pkg
// Shared types, widths and helpers for the ray / ring intersection block.
// ----------------------------------------------------------------------------
package rri_pkg;

	// coordinate and result widths (Q16.16)
	localparam int CW      = 32;
	localparam int RW      = 31;
	localparam int TW      = 31;
	localparam int FRACW   = 16;
	// floor of a 32x32 product back to Q16.16
	localparam int PRODW   = 48;
	// dot products, offsets and magnitudes
	localparam int DOTW    = 50;
	localparam int NUMW    = DOTW;
	localparam int DENW    = DOTW;
	// one quotient bit per divider stage
	localparam int DIVSTEPS = TW;
	// numerator bits fed into the divider after its start
	localparam int NLOW    = TW - FRACW;

	localparam int MIN_DISTANCE    = 66;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int CFG_IDXW = 3;

	typedef enum logic [CFG_IDXW-1:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_CENTER_Z = 3'd5,
		REG_INNER_SQ = 3'd6,
		REG_OUTER_SQ = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic signed [CW-1:0] normal_x;
		logic signed [CW-1:0] normal_y;
		logic signed [CW-1:0] normal_z;
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic signed [CW-1:0] center_z;
		logic [RW-1:0]        inner_radius_sq;
		logic [RW-1:0]        outer_radius_sq;
	} ring_cfg_t;

	typedef struct packed {
		logic signed [CW-1:0] origin_x;
		logic signed [CW-1:0] origin_y;
		logic signed [CW-1:0] origin_z;
		logic signed [CW-1:0] direction_x;
		logic signed [CW-1:0] direction_y;
		logic signed [CW-1:0] direction_z;
	} ray_t;

	// classified ray handed from the front part to the back part
	typedef struct packed {
		logic            miss;
		logic [NUMW-1:0] num;
		logic [DENW-1:0] den;
		ray_t            ray;
	} back_item_t;

	typedef struct packed {
		logic            miss;
		logic            sat;
		logic [DENW-1:0] rem;
		logic [DENW-1:0] den;
		logic [NLOW-1:0] num_lo;
		logic [TW-1:0]   quo;
		ray_t            ray;
	} div_stage_t;

	function automatic logic [DOTW-1:0] mag_dot(input logic signed [DOTW-1:0] v);
		return v[DOTW-1] ? DOTW'(-v) : DOTW'(v);
	endfunction

endpackage

[rtl/ray_ring_intersect.sv]
// ----------------------------------------------------------------------------
// ray_ring_intersect
// Ray against flat ring test, one ray per beat, Q16.16 fixed point.
// The 31-stage divider makes up most of the path from input beat to result.
// Throughput: one ray per cycle while the queue has room and the output is
//   taken; a register write blocks input while the plane offset settles.
// Reset: registers return to the default ring (normal +z, unit outer radius),
//   all pipelines and the queue are emptied.
// ----------------------------------------------------------------------------
module ray_ring_intersect
	import rri_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDXW-1:0]  cfg_index,
	input  logic [CW-1:0]        cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] origin_x,
	input  logic signed [CW-1:0] origin_y,
	input  logic signed [CW-1:0] origin_z,
	input  logic signed [CW-1:0] direction_x,
	input  logic signed [CW-1:0] direction_y,
	input  logic signed [CW-1:0] direction_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [RW-1:0]        hit_distance
);

	ring_cfg_t  cfg_q;
	logic       cfg_hold_q;
	logic       hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_x        <= '0;
			cfg_q.normal_y        <= '0;
			cfg_q.normal_z        <= CW'(32'sd65536);
			cfg_q.center_x        <= '0;
			cfg_q.center_y        <= '0;
			cfg_q.center_z        <= '0;
			cfg_q.inner_radius_sq <= '0;
			cfg_q.outer_radius_sq <= RW'(65536);
			cfg_hold_q            <= 1'b0;
		end else begin
			cfg_hold_q <= cfg_we;
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_NORMAL_X: cfg_q.normal_x        <= cfg_data;
					REG_NORMAL_Y: cfg_q.normal_y        <= cfg_data;
					REG_NORMAL_Z: cfg_q.normal_z        <= cfg_data;
					REG_CENTER_X: cfg_q.center_x        <= cfg_data;
					REG_CENTER_Y: cfg_q.center_y        <= cfg_data;
					REG_CENTER_Z: cfg_q.center_z        <= cfg_data;
					REG_INNER_SQ: cfg_q.inner_radius_sq <= cfg_data[RW-1:0];
					REG_OUTER_SQ: cfg_q.outer_radius_sq <= cfg_data[RW-1:0];
					default: ;
				endcase
			end
		end
	end

	// plane offset lags a write through cfg_q, off_p_q and plane_offset_q
	assign hold = cfg_we || cfg_hold_q;

	logic       item_valid, q_full, q_empty, q_pop, q_push;
	back_item_t item, q_item;

	rri_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.hold        (hold),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.origin_z    (origin_z),
		.direction_x (direction_x),
		.direction_y (direction_y),
		.direction_z (direction_z),
		.item_valid  (item_valid),
		.item        (item),
		.item_full   (q_full)
	);

	assign q_push = item_valid && !q_full;

	rri_fifo #(
		.WIDTH ($bits(back_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (item),
		.pop       (q_pop),
		.pop_data  (q_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	rri_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.hit_distance (hit_distance)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_distance == '0)
		else $error("miss beat carries a nonzero distance");

	a_hit_far_enough: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> hit_distance >= RW'(MIN_DISTANCE))
		else $error("hit reported below the minimum distance");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input taken before the plane offset settled");

endmodule

[rtl/rri_fifo.sv]
// ----------------------------------------------------------------------------
// rri_fifo
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module rri_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	function automatic logic [PTRW-1:0] next_ptr(input logic [PTRW-1:0] p);
		return (p == PTRW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (count_q == CNTW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/rri_front.sv]
// ----------------------------------------------------------------------------
// rri_front
// Takes rays, forms the two plane dot products and sorts out early misses.
// Also keeps the plane offset up to date from the ring registers.
// ----------------------------------------------------------------------------
module rri_front
	import rri_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ring_cfg_t            cfg,
	input  logic                 hold,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] origin_x,
	input  logic signed [CW-1:0] origin_y,
	input  logic signed [CW-1:0] origin_z,
	input  logic signed [CW-1:0] direction_x,
	input  logic signed [CW-1:0] direction_y,
	input  logic signed [CW-1:0] direction_z,
	output logic                 item_valid,
	output back_item_t           item,
	input  logic                 item_full
);

	// plane offset: -(normal . center), saturated to 48 bits
	localparam logic signed [DOTW-1:0] OFF_MAX = {{(DOTW-PRODW+1){1'b0}}, {(PRODW-1){1'b1}}};
	localparam logic signed [DOTW-1:0] OFF_MIN = {{(DOTW-PRODW+1){1'b1}}, {(PRODW-1){1'b0}}};

	logic signed [63:0]       off_full [3];
	logic signed [PRODW-1:0]  off_p_q [3];
	logic signed [DOTW-1:0]   off_neg;
	logic signed [PRODW-1:0]  plane_offset_q;

	always_comb begin
		off_full[0] = cfg.normal_x * cfg.center_x;
		off_full[1] = cfg.normal_y * cfg.center_y;
		off_full[2] = cfg.normal_z * cfg.center_z;
		off_neg = -(DOTW'(off_p_q[0]) + DOTW'(off_p_q[1]) + DOTW'(off_p_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_p_q[0]     <= '0;
			off_p_q[1]     <= '0;
			off_p_q[2]     <= '0;
			plane_offset_q <= '0;
		end else begin
			off_p_q[0] <= off_full[0][63:FRACW];
			off_p_q[1] <= off_full[1][63:FRACW];
			off_p_q[2] <= off_full[2][63:FRACW];
			if (off_neg > OFF_MAX)      plane_offset_q <= PRODW'(OFF_MAX);
			else if (off_neg < OFF_MIN) plane_offset_q <= PRODW'(OFF_MIN);
			else                        plane_offset_q <= PRODW'(off_neg);
		end
	end

	// ray pipeline
	logic                    fe;
	logic                    v_s1, v_s2;
	ray_t                    ray_s1;
	logic signed [PRODW-1:0] dn_s1 [3];
	logic signed [PRODW-1:0] pn_s1 [3];
	logic signed [63:0]      dn_full [3];
	logic signed [63:0]      pn_full [3];
	logic signed [DOTW-1:0]  vd, vo;
	logic [DENW-1:0]         den;
	back_item_t              item_c, item_s2;

	assign fe       = !v_s2 || !item_full;
	assign in_ready = fe && !hold;

	always_comb begin
		dn_full[0] = direction_x * cfg.normal_x;
		dn_full[1] = direction_y * cfg.normal_y;
		dn_full[2] = direction_z * cfg.normal_z;
		pn_full[0] = origin_x * cfg.normal_x;
		pn_full[1] = origin_y * cfg.normal_y;
		pn_full[2] = origin_z * cfg.normal_z;
	end

	always_comb begin
		vd  = DOTW'(dn_s1[0]) + DOTW'(dn_s1[1]) + DOTW'(dn_s1[2]);
		vo  = DOTW'(pn_s1[0]) + DOTW'(pn_s1[1]) + DOTW'(pn_s1[2]) + DOTW'(plane_offset_q);
		den = mag_dot(vd);
		item_c.ray  = ray_s1;
		item_c.den  = den;
		item_c.num  = mag_dot(vo);
		// near parallel, or hit at or behind the start
		item_c.miss = (den < DENW'(MIN_DISTANCE)) || (vo == '0) || (vo[DOTW-1] == vd[DOTW-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fe) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			ray_s1.origin_x    <= origin_x;
			ray_s1.origin_y    <= origin_y;
			ray_s1.origin_z    <= origin_z;
			ray_s1.direction_x <= direction_x;
			ray_s1.direction_y <= direction_y;
			ray_s1.direction_z <= direction_z;
			for (int i = 0; i < 3; i++) begin
				dn_s1[i] <= dn_full[i][63:FRACW];
				pn_s1[i] <= pn_full[i][63:FRACW];
			end
			item_s2 <= item_c;
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;

endmodule

[rtl/rri_back.sv]
// ----------------------------------------------------------------------------
// rri_back
// Pipelined divide for the ray parameter, then hit point and ring test.
// ----------------------------------------------------------------------------
module rri_back
	import rri_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  ring_cfg_t       cfg,
	input  logic            q_empty,
	input  back_item_t      q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            hit,
	output logic [RW-1:0]   hit_distance
);

	logic       be;
	logic       out_valid_q;
	logic       hit_q;
	logic [TW-1:0] dist_q;

	assign be    = !out_valid_q || out_ready;
	assign q_pop = be && !q_empty;

	// divider: stage 0 loads, each later stage settles one quotient bit
	div_stage_t div_s   [DIVSTEPS+1];
	logic       div_v_s [DIVSTEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_v_s[0] <= 1'b0;
		else if (be) div_v_s[0] <= q_pop;
	end

	always_ff @(posedge clk) begin
		if (be) begin
			div_s[0].miss   <= q_item.miss;
			// quotient would not fit 31 bits: saturate
			div_s[0].sat    <= {{(TW-FRACW){1'b0}}, q_item.num} >=
			                   {q_item.den, {(TW-FRACW){1'b0}}};
			div_s[0].rem    <= DENW'(q_item.num >> (TW - FRACW));
			div_s[0].den    <= q_item.den;
			div_s[0].num_lo <= q_item.num[NLOW-1:0];
			div_s[0].quo    <= '0;
			div_s[0].ray    <= q_item.ray;
		end
	end

	for (genvar j = 1; j <= DIVSTEPS; j++) begin : g_div
		localparam int K = DIVSTEPS - j;
		logic          nbit;
		logic [DENW:0] trial, diff;

		if (K >= FRACW) begin : g_num
			assign nbit = div_s[j-1].num_lo[K-FRACW];
		end else begin : g_frac
			assign nbit = 1'b0;
		end

		assign trial = {div_s[j-1].rem, nbit};
		assign diff  = trial - {1'b0, div_s[j-1].den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v_s[j] <= 1'b0;
			else if (be) div_v_s[j] <= div_v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (be) begin
				div_s[j].miss   <= div_s[j-1].miss;
				div_s[j].sat    <= div_s[j-1].sat;
				div_s[j].den    <= div_s[j-1].den;
				div_s[j].num_lo <= div_s[j-1].num_lo;
				div_s[j].ray    <= div_s[j-1].ray;
				div_s[j].rem    <= diff[DENW] ? trial[DENW-1:0] : diff[DENW-1:0];
				div_s[j].quo    <= {div_s[j-1].quo[TW-2:0], !diff[DENW]};
			end
		end
	end

	// stage 1: t and t * direction
	logic [TW-1:0]           t_c;
	logic                    miss_c;
	logic signed [63:0]      td_full [3];
	logic                    v_s1;
	logic                    miss_s1;
	logic [TW-1:0]           t_s1;
	logic signed [PRODW-1:0] td_s1 [3];
	logic signed [CW-1:0]    org_s1 [3];

	always_comb begin
		t_c    = div_s[DIVSTEPS].sat ? '1 : div_s[DIVSTEPS].quo;
		miss_c = div_s[DIVSTEPS].miss || (t_c < TW'(MIN_DISTANCE));
		td_full[0] = $signed({1'b0, t_c}) * div_s[DIVSTEPS].ray.direction_x;
		td_full[1] = $signed({1'b0, t_c}) * div_s[DIVSTEPS].ray.direction_y;
		td_full[2] = $signed({1'b0, t_c}) * div_s[DIVSTEPS].ray.direction_z;
	end

	always_ff @(posedge clk) begin
		if (be) begin
			miss_s1   <= miss_c;
			t_s1      <= t_c;
			org_s1[0] <= div_s[DIVSTEPS].ray.origin_x;
			org_s1[1] <= div_s[DIVSTEPS].ray.origin_y;
			org_s1[2] <= div_s[DIVSTEPS].ray.origin_z;
			for (int i = 0; i < 3; i++) begin
				td_s1[i] <= td_full[i][63:FRACW];
			end
		end
	end

	// stage 2: center minus hit point, magnitudes
	logic signed [CW-1:0]   ctr [3];
	logic signed [DOTW-1:0] off_c [3];
	logic [DOTW-1:0]        mag_c [3];
	logic                   far_c;
	logic                   v_s2;
	logic                   miss_s2;
	logic [TW-1:0]          t_s2;
	logic [CW-1:0]          mag_s2 [3];

	always_comb begin
		ctr[0] = cfg.center_x;
		ctr[1] = cfg.center_y;
		ctr[2] = cfg.center_z;
		far_c  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			off_c[i] = DOTW'(ctr[i]) - (DOTW'(org_s1[i]) + DOTW'(td_s1[i]));
			mag_c[i] = mag_dot(off_c[i]);
			far_c    = far_c || (mag_c[i][DOTW-1:CW] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			miss_s2 <= miss_s1 || far_c;
			t_s2    <= t_s1;
			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= mag_c[i][CW-1:0];
			end
		end
	end

	// stage 3: squares
	logic [63:0]      sq_full [3];
	logic             v_s3;
	logic             miss_s3;
	logic [TW-1:0]    t_s3;
	logic [PRODW-1:0] sq_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_full[i] = 64'(mag_s2[i]) * 64'(mag_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			miss_s3 <= miss_s2;
			t_s3    <= t_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= sq_full[i][63:FRACW];
			end
		end
	end

	// ring test into the output register
	logic [DOTW-1:0] dist_c;
	logic            hit_c;

	always_comb begin
		dist_c = DOTW'(sq_s3[0]) + DOTW'(sq_s3[1]) + DOTW'(sq_s3[2]);
		hit_c  = !miss_s3 && (dist_c >= DOTW'(cfg.inner_radius_sq)) &&
		         (dist_c <= DOTW'(cfg.outer_radius_sq));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (be) begin
			v_s1        <= div_v_s[DIVSTEPS];
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			hit_q  <= hit_c;
			dist_q <= hit_c ? t_s3 : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign hit_distance = dist_q;

endmodule
